### rtl/bml_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bml_pkg
// Shared constants, codes and types of the bilinear map lookup.
// ----------------------------------------------------------------------------
package bml_pkg;

    localparam int MAX_X_POINTS = 16;
    localparam int MAX_Y_POINTS = 16;

    localparam int VAL_W  = 16;
    localparam int Q_W    = 24;
    localparam int IDX_W  = 8;
    localparam int CNT_W  = 5;
    localparam int REG_W  = 5;
    localparam int REGI_W = 1;

    typedef enum logic [1:0] {
        OP_WR_X   = 2'd0,
        OP_WR_Y   = 2'd1,
        OP_WR_CELL = 2'd2,
        OP_LOOKUP = 2'd3
    } t_op;

    localparam logic [REGI_W-1:0] REG_X_COUNT = 1'b0;
    localparam logic [REGI_W-1:0] REG_Y_COUNT = 1'b1;

    typedef struct packed {
        logic [1:0]        operation;
        logic [IDX_W-1:0]  index;
        logic signed [VAL_W-1:0] write_value;
        logic signed [Q_W-1:0]   x_query;
        logic signed [Q_W-1:0]   y_query;
    } t_req;

    // Divider control.
    typedef struct packed {
        logic        start;
        logic [31:0] num;
        logic [16:0] den;
    } t_div_cmd;

    typedef struct packed {
        logic        done;
        logic [31:0] quo;
    } t_div_rsp;

endpackage

### rtl/bml_stream_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bml_stream_if
// Valid/ready channel with a generic payload.
// ----------------------------------------------------------------------------
interface bml_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### rtl/bilinear_map_lookup.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bilinear_map_lookup
// Two-dimensional calibration map with bilinear interpolation.
// ----------------------------------------------------------------------------
//  Channel  | Dir | Payload                                   | Handshake
//  i_req    | in  | operation, index, write_value, x/y_query  | valid/ready
//  o_rsp    | out | map_value                                 | valid/ready
//  cfg      | in  | i_cfg_we, i_cfg_index, i_cfg_data         | write enable
//
// A lookup runs from one transaction to the next as follows: per axis it
// reads the end breakpoints, walks the breakpoint pairs (one RAM read each),
// runs the divider when a pair brackets the query and switches axis; then it
// reads the cells, does six multiplies on one shared 32x18 multiplier and
// loads the output. After reset the cell RAM is swept to zero, one entry a
// cycle, before the first transaction.
// The next request is taken once the result has left the output register.
// ----------------------------------------------------------------------------
module bilinear_map_lookup #(
    parameter int MAX_X_POINTS = bml_pkg::MAX_X_POINTS,
    parameter int MAX_Y_POINTS = bml_pkg::MAX_Y_POINTS
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [bml_pkg::REGI_W-1:0] i_cfg_index,
    input  logic [bml_pkg::REG_W-1:0]  i_cfg_data,
    bml_stream_if.sink                 i_req,
    bml_stream_if.source               o_rsp
);
    localparam int XA_W  = $clog2(MAX_X_POINTS);
    localparam int YA_W  = $clog2(MAX_Y_POINTS);
    localparam int DEPTH = MAX_X_POINTS * MAX_Y_POINTS;
    localparam int CA_W  = $clog2(DEPTH);
    localparam int XC_W  = $clog2(MAX_X_POINTS + 1);
    localparam int YC_W  = $clog2(MAX_Y_POINTS + 1);

    typedef enum logic [14:0] {
        S_CLEAR  = 15'b000000000000001,
        S_IDLE   = 15'b000000000000010,
        S_SRCH   = 15'b000000000000100,
        S_SWAIT  = 15'b000000000001000,
        S_DIV    = 15'b000000000010000,
        S_CELL   = 15'b000000000100000,
        S_MUL    = 15'b000000001000000,
        S_OUT    = 15'b000000010000000,
        S_WRITE  = 15'b000000100000000,
        S_ENDS   = 15'b000001000000000,
        S_ENDW   = 15'b000010000000000,
        S_DIVW   = 15'b000100000000000,
        S_CWAIT  = 15'b001000000000000,
        S_MWAIT  = 15'b010000000000000,
        S_NEXTAX = 15'b100000000000000
    } t_state;

    t_state r_state, n_state;

    // Configuration
    logic [bml_pkg::CNT_W-1:0] r_xcnt, r_ycnt;
    logic [XC_W-1:0] nx;
    logic [YC_W-1:0] ny;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_xcnt <= bml_pkg::CNT_W'(16);
            r_ycnt <= bml_pkg::CNT_W'(16);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                bml_pkg::REG_X_COUNT: r_xcnt <= i_cfg_data;
                bml_pkg::REG_Y_COUNT: r_ycnt <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_xcnt == '0) nx = XC_W'(1);
        else if (32'(r_xcnt) > MAX_X_POINTS) nx = XC_W'(MAX_X_POINTS);
        else nx = XC_W'(r_xcnt);
        if (r_ycnt == '0) ny = YC_W'(1);
        else if (32'(r_ycnt) > MAX_Y_POINTS) ny = YC_W'(MAX_Y_POINTS);
        else ny = YC_W'(r_ycnt);
    end

    // Request register
    bml_pkg::t_req r_req;
    logic r_ax;  // 0: X axis, 1: Y axis

    // Memories
    logic              x_we, y_we, c_we;
    logic [XA_W-1:0]   x_ra;
    logic [YA_W-1:0]   y_ra;
    logic [CA_W-1:0]   c_wa, c_ra;
    logic [15:0]       c_wd, x_rd, y_rd, c_rd;

    bml_ram #(.WIDTH(16), .DEPTH(MAX_X_POINTS)) u_xram (
        .i_clk(i_clk), .i_we(x_we), .i_waddr(r_req.index[XA_W-1:0]),
        .i_wdata(r_req.write_value), .i_raddr(x_ra), .o_rdata(x_rd));
    bml_ram #(.WIDTH(16), .DEPTH(MAX_Y_POINTS)) u_yram (
        .i_clk(i_clk), .i_we(y_we), .i_waddr(r_req.index[YA_W-1:0]),
        .i_wdata(r_req.write_value), .i_raddr(y_ra), .o_rdata(y_rd));
    bml_ram #(.WIDTH(16), .DEPTH(DEPTH)) u_cram (
        .i_clk(i_clk), .i_we(c_we), .i_waddr(c_wa),
        .i_wdata(c_wd), .i_raddr(c_ra), .o_rdata(c_rd));

    // Search state
    logic [6:0]  r_i;               // walk index
    logic        r_rd_i1;           // reading h[i+1] this read
    logic signed [15:0] r_first, r_a, r_b;
    logic [6:0]  r_lo;
    logic [6:0]  r_x0, r_x1, r_y0, r_y1;
    logic [16:0] r_wx1, r_wy1;      // high weights, 65536 max
    logic        r_xeq, r_yeq;
    logic [CA_W-1:0] r_clr;
    logic signed [15:0] r_c [4];
    logic [2:0]  r_step;
    logic signed [47:0] r_acc;
    logic signed [47:0] r_rowlo, r_rowhi;
    logic signed [23:0] r_out;
    logic        r_ovalid;

    logic [6:0] cnt_m1;

    logic signed [23:0] q;
    assign q = r_ax ? r_req.y_query : r_req.x_query;
    assign cnt_m1 = r_ax ? 7'(ny - YC_W'(1)) : 7'(nx - XC_W'(1));

    logic signed [15:0] rd;
    assign rd = r_ax ? y_rd : x_rd;
    logic signed [24:0] a256, first256, rd256, q25;
    assign rd256    = {rd[15], rd, 8'd0};
    assign first256 = {r_first[15], r_first, 8'd0};
    assign a256     = {r_a[15], r_a, 8'd0};
    assign q25 = {q[23], q};

    // Search decisions: breakpoint comparisons signed, end check on unsigned indices.
    logic lo_clamp, hi_clamp, s_exact, s_brkt, s_end;
    assign lo_clamp = first256 >= q25;
    assign hi_clamp = rd256 <= q25;
    assign s_exact  = a256 == q25;
    assign s_brkt   = (a256 <= q25) && (rd256 > q25);
    assign s_end    = (r_lo + 7'd2) > cnt_m1;

    // Divider
    bml_pkg::t_div_cmd div_cmd;
    bml_pkg::t_div_rsp div_rsp;
    bml_div u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(div_cmd), .o_rsp(div_rsp));
    logic signed [24:0] num25;
    logic signed [16:0] span17;
    assign num25  = q25 - a256;
    assign span17 = {r_b[15], r_b} - {r_a[15], r_a};

    // Shared multiplier: 32-bit signed by 18-bit signed
    logic signed [31:0] m_a;
    logic signed [17:0] m_b;
    logic signed [49:0] m_p;
    logic signed [47:0] r_prod;
    assign m_p = m_a * m_b;

    logic signed [17:0] wx0s, wx1s, wy0s, wy1s;
    logic [16:0] wx1e, wy1e;
    assign wx1e = r_xeq ? 17'd32768 : r_wx1;
    assign wy1e = r_yeq ? 17'd32768 : r_wy1;
    assign wx1s = {1'b0, wx1e};
    assign wy1s = {1'b0, wy1e};
    assign wx0s = r_xeq ? 18'sd32768 : 18'sd65536 - wx1s;
    assign wy0s = r_yeq ? 18'sd32768 : 18'sd65536 - wy1s;

    always_comb begin
        m_a = 32'(r_c[0]);
        m_b = wx0s;
        unique case (r_step)
            3'd0: begin m_a = 32'(r_c[0]); m_b = wx0s; end
            3'd1: begin m_a = 32'(r_c[1]); m_b = wx1s; end
            3'd2: begin m_a = 32'(r_c[2]); m_b = wx0s; end
            3'd3: begin m_a = 32'(r_c[3]); m_b = wx1s; end
            3'd4: begin m_a = r_rowlo[31:0]; m_b = wy0s; end
            3'd5: begin m_a = r_rowhi[31:0]; m_b = wy1s; end
            default: begin m_a = '0; m_b = '0; end
        endcase
    end

    // Cell address for read k: row y0/y1, column x0/x1
    logic [6:0] cy, cx;
    logic [13:0] caddr;
    always_comb begin
        cy = r_step[1] ? r_y1 : r_y0;
        cx = r_step[0] ? r_x1 : r_x0;
        caddr = 14'(cy) * 14'(nx) + 14'(cx);
    end

    logic [15:0] cellw_lim;
    assign cellw_lim = 16'(nx) * 16'(ny);

    logic signed [47:0] rnd;
    assign rnd = r_acc + 48'sd8388608;

    logic in_acc, out_acc;
    assign in_acc  = i_req.valid && i_req.ready;
    assign out_acc = o_rsp.valid && o_rsp.ready;
    assign i_req.ready = (r_state == S_IDLE) && !r_ovalid;
    assign o_rsp.valid = r_ovalid;
    assign o_rsp.data  = r_out;

    always_comb begin
        x_we = 1'b0; y_we = 1'b0; c_we = 1'b0;
        c_wa = r_clr; c_wd = '0;
        x_ra = r_i[XA_W-1:0];
        y_ra = r_i[YA_W-1:0];
        c_ra = caddr[CA_W-1:0];
        div_cmd = '0;
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                c_we = 1'b1;
                if (32'(r_clr) == DEPTH - 1) n_state = S_IDLE;
            end
            S_IDLE: if (in_acc) begin
                n_state = (i_req.data.operation == bml_pkg::OP_LOOKUP) ? S_ENDS : S_WRITE;
            end
            S_WRITE: begin
                unique case (r_req.operation)
                    bml_pkg::OP_WR_X: x_we = 16'(r_req.index) < 16'(nx);
                    bml_pkg::OP_WR_Y: y_we = 16'(r_req.index) < 16'(ny);
                    bml_pkg::OP_WR_CELL: begin
                        c_we = 16'(r_req.index) < cellw_lim;
                        c_wa = CA_W'(r_req.index);
                        c_wd = r_req.write_value;
                    end
                    default: ;
                endcase
                n_state = S_IDLE;
            end
            // Read first then last breakpoint.
            S_ENDS:  n_state = S_ENDW;
            S_ENDW:  n_state = S_SWAIT;
            S_SWAIT: n_state = (lo_clamp || hi_clamp) ? S_NEXTAX : S_SRCH;
            S_SRCH: begin
                if (r_rd_i1) begin
                    priority if (s_exact) n_state = S_NEXTAX;
                    else if (s_brkt) n_state = S_DIV;
                    else if (s_end) n_state = S_NEXTAX;
                    else n_state = S_SRCH;
                end
            end
            S_DIV: begin
                div_cmd.start = 1'b1;
                div_cmd.num   = {num25[23:0], 8'd0};
                div_cmd.den   = span17;
                n_state = S_DIVW;
            end
            S_DIVW:  if (div_rsp.done) n_state = S_NEXTAX;
            S_NEXTAX: n_state = r_ax ? S_CELL : S_ENDS;
            S_CELL:  n_state = S_CWAIT;
            S_CWAIT: if (r_step == 3'd4) n_state = S_MUL;
            S_MUL:   n_state = S_MWAIT;
            S_MWAIT: n_state = (r_step == 3'd5) ? S_OUT : S_MUL;
            S_OUT:   n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Sequencer registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_ovalid <= 1'b0;
            r_i      <= '0;
            r_ax     <= 1'b0;
            r_step   <= '0;
        end else begin
            r_state <= n_state;
            if (out_acc) r_ovalid <= 1'b0;
            unique case (r_state)
                S_CLEAR: r_clr <= r_clr + CA_W'(1);
                S_IDLE: if (in_acc) begin
                    r_req <= i_req.data;
                    r_ax  <= 1'b0;
                    r_i   <= '0;
                end
                S_ENDS: r_i <= cnt_m1;           // address of last, first in flight
                S_ENDW: r_first <= rd;           // first breakpoint
                S_SWAIT: begin
                    // rd holds last breakpoint; address index 1 for the walk, h[0] goes to r_a
                    if (lo_clamp) begin
                        r_lo <= '0;
                        if (r_ax) r_yeq <= 1'b1; else r_xeq <= 1'b1;
                        if (r_ax) begin r_y0 <= '0; r_y1 <= '0; end
                        else begin r_x0 <= '0; r_x1 <= '0; end
                    end else if (hi_clamp) begin
                        if (r_ax) begin r_y0 <= cnt_m1; r_y1 <= cnt_m1; r_yeq <= 1'b1; end
                        else begin r_x0 <= cnt_m1; r_x1 <= cnt_m1; r_xeq <= 1'b1; end
                    end else begin
                        r_i <= 7'd1;
                        r_a <= r_first;
                        r_lo <= '0;
                        r_rd_i1 <= 1'b0;
                    end
                end
                S_SRCH: begin
                    // r_a = h[r_lo]; rd = h[r_lo+1] (the RAM read is registered)
                    if (!r_rd_i1) begin
                        r_rd_i1 <= 1'b1;         // wait for the registered read data
                    end else if (s_exact) begin
                        if (r_ax) begin r_y0 <= r_lo; r_y1 <= r_lo; r_yeq <= 1'b1; end
                        else begin r_x0 <= r_lo; r_x1 <= r_lo; r_xeq <= 1'b1; end
                    end else if (s_brkt) begin
                        r_b <= rd;
                        if (r_ax) begin r_y0 <= r_lo; r_y1 <= r_lo + 7'd1; r_yeq <= 1'b0; end
                        else begin r_x0 <= r_lo; r_x1 <= r_lo + 7'd1; r_xeq <= 1'b0; end
                    end else if (s_end) begin
                        if (r_ax) begin r_y0 <= '0; r_y1 <= '0; r_yeq <= 1'b1; end
                        else begin r_x0 <= '0; r_x1 <= '0; r_xeq <= 1'b1; end
                    end else begin
                        r_a <= rd;
                        r_lo <= r_lo + 7'd1;
                        r_i <= r_i + 7'd1;
                        r_rd_i1 <= 1'b0;
                    end
                end
                S_DIVW: if (div_rsp.done) begin
                    if (r_ax) r_wy1 <= div_rsp.quo[16:0];
                    else r_wx1 <= div_rsp.quo[16:0];
                end
                S_NEXTAX: begin
                    r_ax <= 1'b1;
                    r_i  <= '0;
                    r_step <= '0;
                end
                S_CELL: r_step <= r_step + 3'd1;   // read 0 issued
                S_CWAIT: begin
                    r_c[r_step[1:0] - 2'd1] <= c_rd;
                    if (r_step == 3'd4) begin
                        r_step <= '0;
                    end else begin
                        r_step <= r_step + 3'd1;
                    end
                end
                S_MUL: begin
                    r_prod <= m_p[47:0];
                end
                S_MWAIT: begin
                    unique case (r_step)
                        3'd0: r_rowlo <= r_prod;
                        3'd1: r_rowlo <= r_rowlo + r_prod;
                        3'd2: r_rowhi <= r_prod;
                        3'd3: r_rowhi <= r_rowhi + r_prod;
                        3'd4: r_acc <= r_prod;
                        3'd5: r_acc <= r_acc + r_prod;
                        default: ;
                    endcase
                    if (r_step != 3'd5) begin
                        r_step <= r_step + 3'd1;
                    end
                end
                S_OUT: begin
                    r_out <= rnd[47:24];
                    r_ovalid <= 1'b1;
                end
                default: ;
            endcase
            if (r_state == S_ENDS) begin
                if (r_ax) r_yeq <= 1'b0; else r_xeq <= 1'b0;
            end
        end
    end

    // The cell reads use r_step-1 as the read slot while waiting on data.
    // In S_CWAIT, the address for the next read is driven by r_step.

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !i_req.ready)
        else $error("request taken while busy");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && !o_rsp.ready) |=> $stable(o_rsp.data))
        else $error("held result changed");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT) |=> o_rsp.valid)
        else $error("lookup finished without a result");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WRITE) |=> !o_rsp.valid || $past(o_rsp.valid))
        else $error("write produced a result");
endmodule

### rtl/bml_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bml_ram
// Single write port, single registered read port RAM.
// ----------------------------------------------------------------------------
module bml_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

### rtl/bml_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bml_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bml_div (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  bml_pkg::t_div_cmd    i_cmd,
    output bml_pkg::t_div_rsp    o_rsp
);
    logic [31:0] r_quo, n_quo;
    logic [16:0] r_rem, n_rem;
    logic [16:0] r_den;
    logic [5:0]  r_cnt, n_cnt;
    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic [17:0] shifted;
    logic [17:0] diff;

    always_comb begin
        shifted = {r_rem, r_quo[31]};
        diff    = shifted - {1'b0, r_den};
        n_quo   = r_quo;
        n_rem   = r_rem;
        n_cnt   = r_cnt;
        n_busy  = r_busy;
        n_done  = 1'b0;
        if (i_cmd.start) begin
            n_quo  = i_cmd.num;
            n_rem  = '0;
            n_cnt  = 6'd32;
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (!diff[17]) begin
                n_rem = diff[16:0];
                n_quo = {r_quo[30:0], 1'b1};
            end else begin
                n_rem = shifted[16:0];
                n_quo = {r_quo[30:0], 1'b0};
            end
            n_cnt = r_cnt - 6'd1;
            if (r_cnt == 6'd1) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        if (i_cmd.start) begin
            r_den <= i_cmd.den;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;
endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the bilinear map lookup. Loads breakpoints and
// cells, runs lookups under several axis counts with random stalls on both
// channels, and checks every map value against an in-bench calculation.
// ----------------------------------------------------------------------------
module tb;
    import bml_pkg::*;

    localparam int CELLS      = MAX_X_POINTS * MAX_Y_POINTS;
    localparam int STALL_MAX  = 6000;
    localparam int DRAIN_WAIT = 300;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [REGI_W-1:0] i_cfg_index = '0;
    logic [REG_W-1:0]  i_cfg_data = '0;

    bml_stream_if #(.T(t_req)) req_if ();
    bml_stream_if #(.T(logic signed [Q_W-1:0])) rsp_if ();

    bilinear_map_lookup uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_req       (req_if),
        .o_rsp       (rsp_if)
    );

    always #5 i_clk = ~i_clk;

    // Shadow copy of the map and its counts.
    logic signed [VAL_W-1:0] x_bp [MAX_X_POINTS];
    logic signed [VAL_W-1:0] y_bp [MAX_Y_POINTS];
    logic signed [VAL_W-1:0] cell_val [CELLS];
    logic [CNT_W-1:0] x_cnt = 5'd16;
    logic [CNT_W-1:0] y_cnt = 5'd16;

    t_req pending_req [$];
    logic [Q_W-1:0] map_value_q [$];
    int mismatches = 0;
    int stall_cycles = 0;
    logic calm = 1'b0;
    logic hold_req = 1'b0;
    logic hold_done = 1'b0;
    int hold_cnt = 0;

    function automatic int eff_cnt(logic [CNT_W-1:0] c, int max_n);
        if (c == 0) return 1;
        if (c > max_n) return max_n;
        return c;
    endfunction

    function automatic longint bp_at(bit on_y, int k);
        return on_y ? longint'(y_bp[k]) : longint'(x_bp[k]);
    endfunction

    // Bracketing pair and weights (units of 2^-16) on one axis.
    task automatic axis_weights(input bit on_y, input int n, input longint q,
                                output int lo, output int hi,
                                output longint wlo, output longint whi);
        longint a;
        longint b;
        lo = 0;
        hi = 0;
        if (bp_at(on_y, 0) * 256 >= q) begin
            lo = 0;
        end else if (bp_at(on_y, n - 1) * 256 <= q) begin
            lo = n - 1;
            hi = n - 1;
        end else begin
            for (int i = 0; i + 1 < n; i++) begin
                a = bp_at(on_y, i) * 256;
                b = bp_at(on_y, i + 1) * 256;
                if (q == a) begin
                    lo = i;
                    hi = i;
                    break;
                end
                if (a <= q && b > q) begin
                    lo = i;
                    hi = i + 1;
                    break;
                end
            end
        end
        if (lo == hi) begin
            wlo = 32768;
            whi = 32768;
        end else begin
            whi = ((q - bp_at(on_y, lo) * 256) * 256) / (bp_at(on_y, hi) - bp_at(on_y, lo));
            wlo = 65536 - whi;
        end
    endtask

    task automatic apply_req(input t_req r);
        int nx;
        int ny;
        int x0, x1, y0, y1;
        longint wx0, wx1, wy0, wy1, row_lo, row_hi, acc;
        nx = eff_cnt(x_cnt, MAX_X_POINTS);
        ny = eff_cnt(y_cnt, MAX_Y_POINTS);
        case (t_op'(r.operation))
            OP_WR_X: if (r.index < nx) x_bp[r.index] = r.write_value;
            OP_WR_Y: if (r.index < ny) y_bp[r.index] = r.write_value;
            OP_WR_CELL: if (r.index < nx * ny) cell_val[r.index] = r.write_value;
            default: begin
                axis_weights(1'b0, nx, longint'(r.x_query), x0, x1, wx0, wx1);
                axis_weights(1'b1, ny, longint'(r.y_query), y0, y1, wy0, wy1);
                row_lo = longint'(cell_val[(y0 * nx + x0) % CELLS]) * wx0
                       + longint'(cell_val[(y0 * nx + x1) % CELLS]) * wx1;
                row_hi = longint'(cell_val[(y1 * nx + x0) % CELLS]) * wx0
                       + longint'(cell_val[(y1 * nx + x1) % CELLS]) * wx1;
                acc = row_lo * wy0 + row_hi * wy1;
                acc = (acc + (64'sd1 <<< 23)) >>> 24;
                map_value_q.push_back(acc[Q_W-1:0]);
            end
        endcase
    endtask

    // Request driver.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
            req_if.data <= '0;
        end else begin
            if (req_if.valid && req_if.ready) apply_req(req_if.data);
            if (!req_if.valid || req_if.ready) begin
                if (pending_req.size() > 0 && (calm || $urandom_range(99) >= 15)) begin
                    req_if.data <= pending_req.pop_front();
                    req_if.valid <= 1'b1;
                end else begin
                    req_if.valid <= 1'b0;
                end
            end
        end
    end

    // Long hold-off of the result channel, run once on request.
    always @(posedge i_clk) begin
        if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
        end else if (hold_req && !hold_done) begin
            hold_cnt <= 500;
            hold_done <= 1'b1;
        end
    end

    // Result monitor.
    always @(posedge i_clk) begin
        logic [Q_W-1:0] want;
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
        end else begin
            rsp_if.ready <= (hold_cnt == 0) && (calm || $urandom_range(99) >= 15);
            if (rsp_if.valid && rsp_if.ready) begin
                if (map_value_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected map value %h", rsp_if.data);
                end else begin
                    want = map_value_q.pop_front();
                    if (rsp_if.data !== want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("map value mismatch: expected %h, got %h",
                                     want, rsp_if.data);
                    end
                end
            end
        end
    end

    // Watchdog on cycles without any transaction.
    always @(posedge i_clk) begin
        if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles > STALL_MAX) begin
            $display("[bilinear_map_lookup] ERROR");
            $finish;
        end
    end

    function automatic t_req mk_req(t_op op, int idx, int wv, int xq, int yq);
        t_req r;
        r.operation = op;
        r.index = idx[IDX_W-1:0];
        r.write_value = wv[VAL_W-1:0];
        r.x_query = xq[Q_W-1:0];
        r.y_query = yq[Q_W-1:0];
        return r;
    endfunction

    function automatic int rand_val();
        return int'($urandom_range(65535)) - 32768;
    endfunction

    // Rewrites one axis with strictly ascending breakpoints.
    task automatic push_ascending(input t_op op);
        int v;
        v = int'($urandom_range(20000)) - 30000;
        for (int i = 0; i < 16; i++) begin
            pending_req.push_back(mk_req(op, i, v, 0, 0));
            v += int'($urandom_range(3500, 1));
        end
    endtask

    // Query aimed at the interesting spots of one axis.
    function automatic int pick_query(bit on_y, int n);
        int k;
        k = $urandom_range(n - 1);
        case ($urandom_range(5))
            0: return int'($urandom);
            1: return int'(bp_at(on_y, 0)) * 256 - int'($urandom_range(70000));
            2: return int'(bp_at(on_y, n - 1)) * 256 + int'($urandom_range(70000));
            3: return int'(bp_at(on_y, k)) * 256;
            default: return int'(bp_at(on_y, k)) * 256 + int'($urandom_range(600000));
        endcase
    endfunction

    // Waits until the block is idle with nothing outstanding.
    task automatic drain();
        do @(posedge i_clk);
        while (pending_req.size() > 0 || req_if.valid || map_value_q.size() > 0);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic write_count(input logic [REGI_W-1:0] idx, input int val);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val[REG_W-1:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == REG_X_COUNT) x_cnt = val[CNT_W-1:0];
        else y_cnt = val[CNT_W-1:0];
        @(posedge i_clk);
    endtask

    initial begin
        int cx [8];
        int cy [8];
        int sel;
        int nx;
        int ny;
        cx = '{16, 0, 1, 31, 5, 16, 1, 0};
        cy = '{16, 31, 1, 0, 7, 1, 16, 0};
        req_if.valid = 1'b0;
        req_if.data = '0;
        rsp_if.ready = 1'b0;
        foreach (cell_val[i]) cell_val[i] = '0;
        foreach (x_bp[i]) x_bp[i] = '0;
        foreach (y_bp[i]) y_bp[i] = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: full axes, extreme cells, ignored writes, edge lookups.
        for (int i = 0; i < 16; i++) begin
            pending_req.push_back(mk_req(OP_WR_X, i, i * 1000 - 8000, 0, 0));
            pending_req.push_back(mk_req(OP_WR_Y, i, i * 2000 - 32768, 0, 0));
        end
        pending_req.push_back(mk_req(OP_WR_CELL, 0, -32768, 0, 0));
        pending_req.push_back(mk_req(OP_WR_CELL, 1, 32767, 0, 0));
        pending_req.push_back(mk_req(OP_WR_CELL, 16, 32767, 0, 0));
        pending_req.push_back(mk_req(OP_WR_CELL, 17, -32768, 0, 0));
        pending_req.push_back(mk_req(OP_WR_CELL, 255, 32767, 0, 0));
        pending_req.push_back(mk_req(OP_WR_X, 16, 12345, 0, 0));
        pending_req.push_back(mk_req(OP_WR_Y, 255, -1, 0, 0));
        pending_req.push_back(mk_req(OP_LOOKUP, 0, 0, -8000 * 256, -32768 * 256));
        pending_req.push_back(mk_req(OP_LOOKUP, 0, 0, -7500 * 256, -31768 * 256));
        pending_req.push_back(mk_req(OP_LOOKUP, 0, 0, -7000 * 256 + 1, -30768 * 256 - 1));
        pending_req.push_back(mk_req(OP_LOOKUP, 0, 0, -8388608, -8388608));
        pending_req.push_back(mk_req(OP_LOOKUP, 0, 0, 8388607, 8388607));
        pending_req.push_back(mk_req(OP_LOOKUP, 0, 0, 7000 * 256, -2768 * 256));
        pending_req.push_back(mk_req(OP_LOOKUP, 0, 0, -7999 * 256, -32767 * 256));

        for (int ph = 0; ph < 9; ph++) begin
            drain();
            if (ph > 0) begin
                write_count(REG_X_COUNT, ph < 8 ? cx[ph] : $urandom_range(31));
                write_count(REG_Y_COUNT, ph < 8 ? cy[ph] : $urandom_range(31));
            end
            hold_req <= (ph == 2);
            calm <= (ph == 4);
            nx = eff_cnt(x_cnt, MAX_X_POINTS);
            ny = eff_cnt(y_cnt, MAX_Y_POINTS);
            for (int n = 0; n < 55; n++) begin
                sel = $urandom_range(99);
                if (sel < 60) begin
                    // Shadow breakpoints may lag queued writes; only the aim suffers.
                    pending_req.push_back(mk_req(OP_LOOKUP, 0, 0,
                        pick_query(1'b0, nx), pick_query(1'b1, ny)));
                end else if (sel < 82) begin
                    pending_req.push_back(mk_req(OP_WR_CELL,
                        $urandom_range(255), rand_val(), 0, 0));
                end else if (sel < 94) begin
                    pending_req.push_back(mk_req(sel[0] ? OP_WR_X : OP_WR_Y,
                        $urandom_range(20), rand_val(), int'($urandom), int'($urandom)));
                end else if (sel < 97) begin
                    push_ascending(OP_WR_X);
                end else begin
                    push_ascending(OP_WR_Y);
                end
            end
        end
        drain();

        if (mismatches == 0)
            $display("[bilinear_map_lookup] OK");
        else
            $display("[bilinear_map_lookup] ERROR");
        $finish;
    end
endmodule
